// File: hw/rtl/hrlf_pkg.sv
// hrlf_pkg: shared types, constants and match tables for the HTTP request framer.
// No dependencies; every module of the framer imports it, the stream interfaces do not.
package hrlf_pkg;

    localparam int HRLF_MAX_HEADER = 2048;
    localparam int HRLF_LEN_BITS   = 32;

    localparam int FIELD_LEN = 18;
    localparam int END_LEN   = 4;
    localparam int FM_W      = $clog2(FIELD_LEN + 1);
    localparam int EM_W      = $clog2(END_LEN + 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        LP_SEARCH = 2'd0,
        LP_SPACES = 2'd1,
        LP_DIGITS = 2'd2,
        LP_DONE   = 2'd3
    } length_phase_t;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        in_header;
        logic        last;
        logic        error;
        logic [15:0] dest_service;
    } hrlf_result_t;

    // "\r\nContent-Length: "
    function automatic logic [7:0] field_char(input logic [FM_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = CHAR_CR;
            5'd1:    c = CHAR_LF;
            5'd2:    c = 8'h43;
            5'd3:    c = 8'h6F;
            5'd4:    c = 8'h6E;
            5'd5:    c = 8'h74;
            5'd6:    c = 8'h65;
            5'd7:    c = 8'h6E;
            5'd8:    c = 8'h74;
            5'd9:    c = 8'h2D;
            5'd10:   c = 8'h4C;
            5'd11:   c = 8'h65;
            5'd12:   c = 8'h6E;
            5'd13:   c = 8'h67;
            5'd14:   c = 8'h74;
            5'd15:   c = 8'h68;
            5'd16:   c = 8'h3A;
            5'd17:   c = CHAR_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // CR LF CR LF
    function automatic logic [7:0] end_char(input logic [EM_W-1:0] idx);
        return idx[0] ? CHAR_LF : CHAR_CR;
    endfunction

endpackage

// File: hw/rtl/hrlf_stream_if.sv
// Valid/ready stream interfaces for the framer's byte input and result output.
// Depends on hrlf_pkg for nothing but keeps the same naming; no other dependencies.
interface hrlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

interface hrlf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_out;
    logic        in_header;
    logic        last;
    logic        error;
    logic [15:0] dest_service;

    modport source (output valid, output data_out, output in_header, output last,
                    output error, output dest_service, input ready);
    modport sink   (input valid, input data_out, input in_header, input last,
                    input error, input dest_service, output ready);
endinterface

// File: hw/rtl/hrlf_frame_state.sv
// Framing state and per-byte update: header-end match, length field parse, body count.
// Depends on hrlf_pkg.
module hrlf_frame_state
    import hrlf_pkg::*;
#(
    parameter int MAX_HEADER = HRLF_MAX_HEADER,
    parameter int LEN_BITS   = HRLF_LEN_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    output logic       in_header,
    output logic       last,
    output logic       error
);

    localparam int HC_W = $clog2(MAX_HEADER + 1);
    localparam logic [HC_W-1:0] HDR_CAP = HC_W'(MAX_HEADER);

    logic [EM_W-1:0]     end_match_reg,    end_match_next;
    logic [FM_W-1:0]     field_match_reg,  field_match_next;
    length_phase_t       phase_reg,        phase_next;
    logic [LEN_BITS-1:0] length_value_reg, length_value_next;
    logic [HC_W-1:0]     header_count_reg, header_count_next;
    logic                in_body_reg,      in_body_next;
    logic [LEN_BITS-1:0] body_left_reg,    body_left_next;

    logic                is_digit;
    logic [LEN_BITS+3:0] scaled;
    logic                len_ovf;
    logic                done;
    logic                err;
    logic [LEN_BITS-1:0] len_now;
    logic [EM_W-1:0]     em_new;

    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign scaled   = ({4'd0, length_value_reg} << 3) + ({4'd0, length_value_reg} << 1)
                      + {{LEN_BITS{1'b0}}, data_byte[3:0]};
    assign len_ovf  = |scaled[LEN_BITS+3:LEN_BITS];

    always_comb
    begin
        end_match_next    = end_match_reg;
        field_match_next  = field_match_reg;
        phase_next        = phase_reg;
        length_value_next = length_value_reg;
        header_count_next = header_count_reg;
        in_body_next      = in_body_reg;
        body_left_next    = body_left_reg;
        in_header         = 1'b1;
        last              = 1'b0;
        err               = 1'b0;
        done              = 1'b0;
        len_now           = length_value_reg;
        em_new            = end_match_reg;

        if (in_body_reg)
        begin
            in_header = 1'b0;
            if (body_left_reg <= LEN_BITS'(1))
            begin
                last           = 1'b1;
                in_body_next   = 1'b0;
                body_left_next = '0;
            end
            else
            begin
                body_left_next = body_left_reg - LEN_BITS'(1);
            end
        end
        else
        begin
            header_count_next = header_count_reg + HC_W'(1);

            case (phase_reg)
                LP_SEARCH:
                begin
                    if (field_match_reg < FM_W'(FIELD_LEN)
                        && data_byte == field_char(field_match_reg))
                        field_match_next = field_match_reg + FM_W'(1);
                    else
                        field_match_next = (data_byte == CHAR_CR) ? FM_W'(1) : '0;
                    if (field_match_next == FM_W'(FIELD_LEN))
                    begin
                        phase_next        = LP_SPACES;
                        length_value_next = '0;
                    end
                end
                LP_SPACES:
                begin
                    if (is_digit)
                    begin
                        length_value_next = LEN_BITS'(data_byte[3:0]);
                        phase_next        = LP_DIGITS;
                    end
                    else if (data_byte != CHAR_SPACE)
                        err = 1'b1;
                end
                LP_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (len_ovf)
                            err = 1'b1;
                        else
                            length_value_next = scaled[LEN_BITS-1:0];
                    end
                    else
                        phase_next = LP_DONE;
                end
                default:
                begin
                end
            endcase

            if (end_match_reg < EM_W'(END_LEN) && data_byte == end_char(end_match_reg))
                em_new = end_match_reg + EM_W'(1);
            else
                em_new = (data_byte == CHAR_CR) ? EM_W'(1) : '0;
            end_match_next = em_new;
            done           = (em_new == EM_W'(END_LEN));
            len_now        = length_value_next;

            if (err || done || header_count_next >= HDR_CAP)
            begin
                end_match_next    = '0;
                field_match_next  = '0;
                phase_next        = LP_SEARCH;
                length_value_next = '0;
                header_count_next = '0;
                in_body_next      = 1'b0;
                body_left_next    = '0;
                if (!err && done)
                begin
                    if (len_now == '0)
                        last = 1'b1;
                    else
                    begin
                        in_body_next   = 1'b1;
                        body_left_next = len_now;
                    end
                end
                else if (!err)
                    err = 1'b1;  // header cap reached
            end
        end
    end

    assign error = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_match_reg    <= '0;
            field_match_reg  <= '0;
            phase_reg        <= LP_SEARCH;
            length_value_reg <= '0;
            header_count_reg <= '0;
            in_body_reg      <= 1'b0;
            body_left_reg    <= '0;
        end
        else if (step)
        begin
            end_match_reg    <= end_match_next;
            field_match_reg  <= field_match_next;
            phase_reg        <= phase_next;
            length_value_reg <= length_value_next;
            header_count_reg <= header_count_next;
            in_body_reg      <= in_body_next;
            body_left_reg    <= body_left_next;
        end
    end

endmodule

// File: hw/rtl/hrlf_out_stage.sv
// Result register with valid/ready handshake; frees itself in the cycle it is taken.
// Depends on hrlf_pkg and hrlf_out_if.
module hrlf_out_stage
    import hrlf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  hrlf_result_t result,
    output logic         can_load,
    hrlf_out_if.source   out_stream
);

    logic         valid_reg, valid_next;
    hrlf_result_t result_reg;

    assign can_load   = !valid_reg || out_stream.ready;
    assign valid_next = load || (valid_reg && !out_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign out_stream.valid        = valid_reg;
    assign out_stream.data_out     = result_reg.data_out;
    assign out_stream.in_header    = result_reg.in_header;
    assign out_stream.last         = result_reg.last;
    assign out_stream.error        = result_reg.error;
    assign out_stream.dest_service = result_reg.dest_service;

endmodule

// File: hw/rtl/http_request_length_framer.sv
// HTTP request framer, top level: one byte transaction in, one flagged byte transaction out.
// Result is valid in the cycle after a byte is accepted; 1 byte per cycle while the output
// is not held by ready, set by the combinational state update feeding the result register.
// Reset clears all framing state, the service tag and the result valid flag.
// Depends on hrlf_pkg, hrlf_stream_if, hrlf_frame_state, hrlf_out_stage.
module http_request_length_framer
    import hrlf_pkg::*;
#(
    parameter int MAX_HEADER = HRLF_MAX_HEADER,
    parameter int LEN_BITS   = HRLF_LEN_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    hrlf_in_if.sink     in_stream,
    hrlf_out_if.source  out_stream
);

    logic         accept;
    logic         can_load;
    logic         hdr_flag;
    logic         last_flag;
    logic         err_flag;
    logic [15:0]  service_tag_reg;
    hrlf_result_t result;

    assign in_stream.ready = can_load;
    assign accept          = in_stream.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            service_tag_reg <= '0;
        else if (cfg_wr_en)
            service_tag_reg <= cfg_wr_data;
    end

    hrlf_frame_state #(
        .MAX_HEADER (MAX_HEADER),
        .LEN_BITS   (LEN_BITS)
    ) u_frame_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (in_stream.data_in),
        .in_header (hdr_flag),
        .last      (last_flag),
        .error     (err_flag)
    );

    always_comb
    begin
        result.data_out     = in_stream.data_in;
        result.in_header    = hdr_flag;
        result.last         = last_flag;
        result.error        = err_flag;
        result.dest_service = service_tag_reg;
    end

    hrlf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result     (result),
        .can_load   (can_load),
        .out_stream (out_stream)
    );

endmodule
